[design/cag_pkg.sv]
// Shared constants, codes and types of the cave automaton grid engine.
package cag_pkg;

  // Grid capacity.
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // Derived widths.
  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int X_W    = $clog2(MAX_COLS);
  localparam int Y_W    = $clog2(MAX_ROWS);
  localparam int COLS_W = $clog2(MAX_COLS + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);

  // Fixed field widths of the channels and the configuration port.
  localparam int OPC_W      = 2;
  localparam int IDX_W      = 12;
  localparam int DIM_W      = 7;
  localparam int PASS_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Command codes.
  typedef enum logic [OPC_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS    = 2'd0,
    CFG_GRID_ROWS    = 2'd1,
    CFG_SMOOTH_PASS  = 2'd2,
    CFG_CLEANUP_PASS = 2'd3
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIVIDE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_LAST   = 6'b001000,
    ST_COPY   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Kind of sweep in progress.
  typedef enum logic [1:0] {
    PH_SMOOTH = 2'd0,
    PH_CLEAN  = 2'd1,
    PH_FINAL  = 2'd2,
    PH_READ   = 2'd3
  } phase_t;

  // Role of a neighbor read within the 5x5 window.
  typedef enum logic [1:0] {
    NB_CENTER = 2'd0,
    NB_RING1  = 2'd1,
    NB_RING2  = 2'd2
  } nb_kind_t;

endpackage

[design/cag_if.sv]
// Valid/ready channel interfaces for commands and results.
interface cag_in_if import cag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [IDX_W-1:0] cell_index;
  logic             wall_in;

  modport source (output valid, opcode, cell_index, wall_in, input ready);
  modport sink (input valid, opcode, cell_index, wall_in, output ready);
endinterface

interface cag_out_if;
  logic valid;
  logic ready;
  logic wall_out;
  logic border_out;
  logic op_done;

  modport source (output valid, wall_out, border_out, op_done, input ready);
  modport sink (input valid, wall_out, border_out, op_done, output ready);
endinterface

[design/cave_automaton_grid_engine.sv]
// Cave automaton grid engine: grid memories, neighborhood sequencer and result register.
//
// Commands arrive on in_ch, one transaction each; every command yields one result
// transaction on out_ch. Configuration is to be written through cfg_we/cfg_index/
// cfg_wdata only while the engine is idle; the block itself does not enforce this.
// A write command's result is registered in the cycle in which it is accepted.
// A read command first splits the index into row and column by repeated subtraction,
// then reads the 3x3 window from the grid memory one cell a cycle, then passes
// through ST_LAST and ST_DONE to hand over the result.
// A run command sweeps the grid once per pass. Each cell reads its window one position
// a cycle (5x5 in a smoothing pass, 3x3 in a cleanup or the final pass), then ST_LAST.
// Every smoothing and cleanup pass is followed by a copy sweep from the scratch memory
// into the grid memory.
// Reset (synchronous, rst_n low) returns the registers to 64x64 with four smoothing
// and six cleanup passes and empties the result register; memory contents are kept.
// A waiting result does not block a new command as long as it is taken in the same
// cycle; when the receiver stalls, the result holds and no new command is accepted.
module cave_automaton_grid_engine import cag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cag_in_if.sink                in_ch,
  cag_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [DIM_W-1:0]  cfg_cols_r, cfg_rows_r;
  logic [PASS_W-1:0] cfg_smooth_r, cfg_clean_r;

  // Sequencer state.
  state_t             state_r;
  phase_t             phase_r;
  logic [PASS_W-1:0]  pass_r;
  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [ADDR_W-1:0]  cur_idx_r;
  logic [ADDR_W-1:0]  rem_r;
  logic [2:0]         u_r, v_r;
  logic               pend_vld_r;
  nb_kind_t           pend_kind_r;
  logic [3:0]         r1_r;
  logic [4:0]         r2_r;
  logic               ctr_r;
  logic [CNT_W-1:0]   cp_addr_r;
  logic               cpw_vld_r;
  logic [ADDR_W-1:0]  cpw_addr_r;
  logic               res_wall_r, res_border_r;

  // Memories and their registered read data.
  logic cell_mem [MAX_COLS*MAX_ROWS];
  logic next_mem [MAX_COLS*MAX_ROWS];
  logic crd_r, nrd_r;

  // Result register.
  logic out_valid_r, out_wall_r, out_border_r, out_done_r;

  // Geometry after saturation.
  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic [CNT_W-1:0]  n_cells;

  always_comb begin
    if (cfg_cols_r < DIM_W'(3)) begin
      eff_cols = COLS_W'(3);
    end else if (32'(cfg_cols_r) > MAX_COLS) begin
      eff_cols = COLS_W'(MAX_COLS);
    end else begin
      eff_cols = COLS_W'(cfg_cols_r);
    end
    if (cfg_rows_r < DIM_W'(3)) begin
      eff_rows = ROWS_W'(3);
    end else if (32'(cfg_rows_r) > MAX_ROWS) begin
      eff_rows = ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = ROWS_W'(cfg_rows_r);
    end
    n_cells = CNT_W'(eff_cols) * CNT_W'(eff_rows);
  end

  // Handshake.
  logic    out_free, in_acc, idx_ok;
  opcode_t in_op;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_op = opcode_t'(in_ch.opcode);
  assign idx_ok = 32'(in_ch.cell_index) < 32'(n_cells);

  // Window bounds of the current sweep: 5x5 for smoothing, 3x3 otherwise.
  logic [2:0] win_lo, win_hi;
  assign win_lo = (phase_r == PH_SMOOTH) ? 3'd0 : 3'd1;
  assign win_hi = (phase_r == PH_SMOOTH) ? 3'd4 : 3'd3;

  // Neighbor position, bounds check and address.
  logic signed [X_W+1:0]    nx;
  logic signed [Y_W+1:0]    ny;
  logic                     nb_inb;
  logic signed [ADDR_W+1:0] cols_s, roff, na_full;
  logic [ADDR_W-1:0]        na;
  nb_kind_t                 nb_kind;

  always_comb begin
    nx = $signed({2'b00, x_r}) + $signed({{(X_W-1){1'b0}}, u_r}) - $signed((X_W+2)'(2));
    ny = $signed({2'b00, y_r}) + $signed({{(Y_W-1){1'b0}}, v_r}) - $signed((Y_W+2)'(2));
    nb_inb = !nx[X_W+1] && !ny[Y_W+1]
          && (nx < $signed((X_W+2)'(eff_cols)))
          && (ny < $signed((Y_W+2)'(eff_rows)));
    cols_s = $signed((ADDR_W+2)'(eff_cols));
    unique case (v_r)
      3'd0:    roff = -(cols_s + cols_s);
      3'd1:    roff = -cols_s;
      3'd3:    roff = cols_s;
      3'd4:    roff = cols_s + cols_s;
      default: roff = '0;
    endcase
    na_full = $signed({2'b00, cur_idx_r}) + roff
            + $signed({{(ADDR_W-1){1'b0}}, u_r}) - $signed((ADDR_W+2)'(2));
    na = na_full[ADDR_W-1:0];
    if (u_r == 3'd2 && v_r == 3'd2) begin
      nb_kind = NB_CENTER;
    end else if (u_r >= 3'd1 && u_r <= 3'd3 && v_r >= 3'd1 && v_r <= 3'd3) begin
      nb_kind = NB_RING1;
    end else begin
      nb_kind = NB_RING2;
    end
  end

  // Final counts, including the read still in flight.
  logic [3:0] r1_fin;
  logic [4:0] r2_fin;
  logic       ctr_fin;
  logic [4:0] a1;
  logic [5:0] a2;
  logic       near_edge, on_frame, last_row, last_col, smooth_val, clean_val, new_val;

  always_comb begin
    r1_fin  = r1_r + 4'(pend_vld_r && pend_kind_r == NB_RING1 && crd_r);
    r2_fin  = r2_r + 5'(pend_vld_r && pend_kind_r == NB_RING2 && crd_r);
    ctr_fin = (pend_vld_r && pend_kind_r == NB_CENTER) ? crd_r : ctr_r;
    last_col = (COLS_W'(x_r) == eff_cols - COLS_W'(1));
    last_row = (ROWS_W'(y_r) == eff_rows - ROWS_W'(1));
    on_frame = (x_r == '0) || (y_r == '0) || last_col || last_row;
    near_edge = (x_r <= X_W'(1)) || (y_r <= Y_W'(1))
             || ((COLS_W+1)'(x_r) + (COLS_W+1)'(2) >= (COLS_W+1)'(eff_cols))
             || ((ROWS_W+1)'(y_r) + (ROWS_W+1)'(2) >= (ROWS_W+1)'(eff_rows));
    a1 = 5'(r1_fin) + (near_edge ? 5'd4 : 5'd0);
    a2 = 6'(r2_fin) + (near_edge ? 6'd5 : 6'd0);
    smooth_val = ctr_fin ? (a1 >= 5'd4 && a2 >= 6'd8) : (a1 >= 5'd5 || a2 >= 6'd8);
    clean_val  = on_frame || (ctr_fin ? (r1_fin >= 4'd4) : (r1_fin >= 4'd5));
    new_val    = (phase_r == PH_SMOOTH) ? smooth_val : clean_val;
  end

  // Grid memory write port and result push selection.
  logic              cw_en, cw_data;
  logic [ADDR_W-1:0] cw_addr;
  logic              push, push_wall, push_border, push_done;

  always_comb begin
    cw_en = 1'b0;
    cw_addr = cur_idx_r;
    cw_data = new_val;
    push = 1'b0;
    push_wall = 1'b0;
    push_border = 1'b0;
    push_done = 1'b1;
    if (in_acc) begin
      unique case (in_op)
        OP_WRITE: begin
          cw_en = idx_ok;
          cw_addr = ADDR_W'(in_ch.cell_index);
          cw_data = in_ch.wall_in;
          push = 1'b1;
        end
        OP_READ: push = !idx_ok;
        OP_RUN:  push = 1'b0;
        default: begin
          push = 1'b1;
          push_done = 1'b0;
        end
      endcase
    end else if (state_r == ST_LAST && phase_r == PH_FINAL) begin
      cw_en = 1'b1;
    end else if (state_r == ST_COPY && cpw_vld_r) begin
      cw_en = 1'b1;
      cw_addr = cpw_addr_r;
      cw_data = nrd_r;
    end else if (state_r == ST_DONE && out_free) begin
      push = 1'b1;
      push_wall = res_wall_r;
      push_border = res_border_r;
    end
  end

  // Grid memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cw_en) begin
      cell_mem[cw_addr] <= cw_data;
    end
    crd_r <= cell_mem[na];
  end

  // Scratch memory for the synchronous passes.
  always_ff @(posedge clk) begin
    if (state_r == ST_LAST && (phase_r == PH_SMOOTH || phase_r == PH_CLEAN)) begin
      next_mem[cur_idx_r] <= new_val;
    end
    nrd_r <= next_mem[cp_addr_r[ADDR_W-1:0]];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r   <= DIM_W'(64);
      cfg_rows_r   <= DIM_W'(64);
      cfg_smooth_r <= PASS_W'(4);
      cfg_clean_r  <= PASS_W'(6);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_COLS:    cfg_cols_r   <= cfg_wdata[DIM_W-1:0];
        CFG_GRID_ROWS:    cfg_rows_r   <= cfg_wdata[DIM_W-1:0];
        CFG_SMOOTH_PASS:  cfg_smooth_r <= cfg_wdata[PASS_W-1:0];
        CFG_CLEANUP_PASS: cfg_clean_r  <= cfg_wdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase that follows the smoothing passes.
  phase_t after_smooth;
  assign after_smooth = (cfg_clean_r != '0) ? PH_CLEAN : PH_FINAL;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_READ;
      pass_r     <= '0;
      pend_vld_r <= 1'b0;
      cpw_vld_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_op == OP_RUN) begin
            pass_r <= '0;
            x_r <= '0;
            y_r <= '0;
            cur_idx_r <= '0;
            r1_r <= '0;
            r2_r <= '0;
            ctr_r <= 1'b0;
            pend_vld_r <= 1'b0;
            state_r <= ST_SCAN;
            if (cfg_smooth_r != '0) begin
              phase_r <= PH_SMOOTH;
              u_r <= 3'd0;
              v_r <= 3'd0;
            end else begin
              phase_r <= after_smooth;
              u_r <= 3'd1;
              v_r <= 3'd1;
            end
          end else if (in_acc && in_op == OP_READ && idx_ok) begin
            rem_r <= ADDR_W'(in_ch.cell_index);
            cur_idx_r <= ADDR_W'(in_ch.cell_index);
            y_r <= '0;
            state_r <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          // Split the index into row and column one subtraction a cycle.
          if (32'(rem_r) >= 32'(eff_cols)) begin
            rem_r <= rem_r - ADDR_W'(eff_cols);
            y_r <= y_r + Y_W'(1);
          end else begin
            x_r <= rem_r[X_W-1:0];
            phase_r <= PH_READ;
            u_r <= 3'd1;
            v_r <= 3'd1;
            r1_r <= '0;
            r2_r <= '0;
            ctr_r <= 1'b0;
            pend_vld_r <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Count the neighbor read issued in the previous cycle and issue the next one.
          if (pend_vld_r) begin
            unique case (pend_kind_r)
              NB_CENTER: ctr_r <= crd_r;
              NB_RING1:  r1_r <= r1_r + 4'(crd_r);
              NB_RING2:  r2_r <= r2_r + 5'(crd_r);
              default: ;
            endcase
          end
          pend_vld_r <= nb_inb;
          pend_kind_r <= nb_kind;
          if (v_r == win_hi) begin
            v_r <= win_lo;
            if (u_r == win_hi) begin
              state_r <= ST_LAST;
            end else begin
              u_r <= u_r + 3'd1;
            end
          end else begin
            v_r <= v_r + 3'd1;
          end
        end
        ST_LAST: begin
          // In a sweep the cell is written by the write ports and the next cell follows; a read hands over its result.
          pend_vld_r <= 1'b0;
          r1_r <= '0;
          r2_r <= '0;
          ctr_r <= 1'b0;
          u_r <= win_lo;
          v_r <= win_lo;
          if (phase_r == PH_READ) begin
            res_wall_r <= ctr_fin;
            res_border_r <= !ctr_fin && (r1_fin != '0);
            state_r <= ST_DONE;
          end else if (last_row && last_col) begin
            if (phase_r == PH_FINAL) begin
              res_wall_r <= 1'b0;
              res_border_r <= 1'b0;
              state_r <= ST_DONE;
            end else begin
              cp_addr_r <= '0;
              cpw_vld_r <= 1'b0;
              state_r <= ST_COPY;
            end
          end else if (last_row) begin
            y_r <= '0;
            x_r <= x_r + X_W'(1);
            cur_idx_r <= ADDR_W'(x_r) + ADDR_W'(1);
            state_r <= ST_SCAN;
          end else begin
            y_r <= y_r + Y_W'(1);
            cur_idx_r <= cur_idx_r + ADDR_W'(eff_cols);
            state_r <= ST_SCAN;
          end
        end
        ST_COPY: begin
          // Scratch into grid, each read registered ahead of its write.
          cpw_vld_r <= cp_addr_r < n_cells;
          cpw_addr_r <= cp_addr_r[ADDR_W-1:0];
          if (cp_addr_r < n_cells) begin
            cp_addr_r <= cp_addr_r + CNT_W'(1);
          end else if (!cpw_vld_r) begin
            x_r <= '0;
            y_r <= '0;
            cur_idx_r <= '0;
            state_r <= ST_SCAN;
            if (phase_r == PH_SMOOTH && pass_r + PASS_W'(1) < cfg_smooth_r) begin
              // Another smoothing pass with the 5x5 window.
              pass_r <= pass_r + PASS_W'(1);
              u_r <= 3'd0;
              v_r <= 3'd0;
            end else begin
              u_r <= 3'd1;
              v_r <= 3'd1;
              if (phase_r == PH_SMOOTH) begin
                pass_r <= '0;
                phase_r <= after_smooth;
              end else if (pass_r + PASS_W'(1) < cfg_clean_r) begin
                pass_r <= pass_r + PASS_W'(1);
              end else begin
                pass_r <= '0;
                phase_r <= PH_FINAL;
              end
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_wall_r <= push_wall;
      out_border_r <= push_border;
      out_done_r <= push_done;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.wall_out = out_wall_r;
  assign out_ch.border_out = out_border_r;
  assign out_ch.op_done = out_done_r;

endmodule
